// File: hdl/qvt_pkg.sv
// Shared widths, register indexes and configuration bundle for the quaternion vertex transform.
package qvt_pkg;

    // Field formats
    localparam int COORD_BITS = 24;              // Q16.8 coordinate
    localparam int QUAT_BITS  = 16;              // Q1.15 quaternion part
    localparam int QUAT_FRAC  = QUAT_BITS - 1;

    // Datapath widths
    localparam int P1_W = COORD_BITS + QUAT_BITS;     // q * p product
    localparam int S1_W = P1_W + 2;                   // three-term sum
    localparam int R_W  = S1_W - QUAT_FRAC;           // rounded first product
    localparam int P2_W = R_W + QUAT_BITS;            // r * q product
    localparam int S2_W = P2_W + 2;                   // four-term sum
    localparam int O_W  = S2_W - QUAT_FRAC + 1;       // rounded plus translation

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } qvt_reg_t;

    // Register contents handed to the datapath
    typedef struct packed {
        logic signed [QUAT_BITS-1:0]  rot_w;
        logic signed [QUAT_BITS-1:0]  rot_x;
        logic signed [QUAT_BITS-1:0]  rot_y;
        logic signed [QUAT_BITS-1:0]  rot_z;
        logic signed [COORD_BITS-1:0] shift_x;
        logic signed [COORD_BITS-1:0] shift_y;
        logic signed [COORD_BITS-1:0] shift_z;
    } qvt_cfg_t;

endpackage

// File: hdl/qvt_datapath.sv
// Five-stage pipelined rotate, translate and saturate datapath.
module qvt_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  qvt_pkg::qvt_cfg_t                      cfg,
    input  logic                                   in_valid,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_x,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_y,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_z,
    output logic                                   out_valid,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_x,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_y,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_z,
    output logic                                   out_ovf
);
    import qvt_pkg::*;

    localparam logic signed [S1_W-1:0] HALF1 = S1_W'(1) <<< (QUAT_FRAC - 1);
    localparam logic signed [S2_W-1:0] HALF2 = S2_W'(1) <<< (QUAT_FRAC - 1);
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Valid bits, one per stage
    logic [4:0] vld_reg;
    logic [4:0] vld_next;

    // Stage registers
    logic signed [P1_W-1:0] m_reg [12];
    logic signed [P1_W-1:0] m_next [12];
    logic signed [R_W-1:0]  r_reg [4];     // w, x, y, z
    logic signed [R_W-1:0]  r_next [4];
    logic signed [P2_W-1:0] n_reg [12];
    logic signed [P2_W-1:0] n_next [12];
    logic signed [O_W-1:0]  o_reg [3];
    logic signed [O_W-1:0]  o_next [3];
    logic signed [COORD_BITS-1:0] res_reg [3];
    logic signed [COORD_BITS-1:0] res_next [3];
    logic ovf_reg;
    logic ovf_next;

    logic signed [S1_W-1:0] s1 [4];
    logic signed [S2_W-1:0] s2 [3];
    logic [2:0] sat;

    // Stage 1: products of q and the vertex
    always_comb
    begin
        m_next[0]  = P1_W'(cfg.rot_x) * P1_W'(in_x);
        m_next[1]  = P1_W'(cfg.rot_y) * P1_W'(in_y);
        m_next[2]  = P1_W'(cfg.rot_z) * P1_W'(in_z);
        m_next[3]  = P1_W'(cfg.rot_w) * P1_W'(in_x);
        m_next[4]  = P1_W'(cfg.rot_y) * P1_W'(in_z);
        m_next[5]  = P1_W'(cfg.rot_z) * P1_W'(in_y);
        m_next[6]  = P1_W'(cfg.rot_w) * P1_W'(in_y);
        m_next[7]  = P1_W'(cfg.rot_x) * P1_W'(in_z);
        m_next[8]  = P1_W'(cfg.rot_z) * P1_W'(in_x);
        m_next[9]  = P1_W'(cfg.rot_w) * P1_W'(in_z);
        m_next[10] = P1_W'(cfg.rot_x) * P1_W'(in_y);
        m_next[11] = P1_W'(cfg.rot_y) * P1_W'(in_x);
    end

    // Stage 2: r = q * (0, p), rounded half up
    always_comb
    begin
        s1[0] = -S1_W'(m_reg[0]) - S1_W'(m_reg[1])  - S1_W'(m_reg[2]);
        s1[1] =  S1_W'(m_reg[3]) + S1_W'(m_reg[4])  - S1_W'(m_reg[5]);
        s1[2] =  S1_W'(m_reg[6]) - S1_W'(m_reg[7])  + S1_W'(m_reg[8]);
        s1[3] =  S1_W'(m_reg[9]) + S1_W'(m_reg[10]) - S1_W'(m_reg[11]);
        for (int i = 0; i < 4; i++)
        begin
            r_next[i] = R_W'((s1[i] + HALF1) >>> QUAT_FRAC);
        end
    end

    // Stage 3: products of r and q
    always_comb
    begin
        n_next[0]  = P2_W'(r_reg[0]) * P2_W'(cfg.rot_x);
        n_next[1]  = P2_W'(r_reg[1]) * P2_W'(cfg.rot_w);
        n_next[2]  = P2_W'(r_reg[2]) * P2_W'(cfg.rot_z);
        n_next[3]  = P2_W'(r_reg[3]) * P2_W'(cfg.rot_y);
        n_next[4]  = P2_W'(r_reg[0]) * P2_W'(cfg.rot_y);
        n_next[5]  = P2_W'(r_reg[2]) * P2_W'(cfg.rot_w);
        n_next[6]  = P2_W'(r_reg[1]) * P2_W'(cfg.rot_z);
        n_next[7]  = P2_W'(r_reg[3]) * P2_W'(cfg.rot_x);
        n_next[8]  = P2_W'(r_reg[0]) * P2_W'(cfg.rot_z);
        n_next[9]  = P2_W'(r_reg[3]) * P2_W'(cfg.rot_w);
        n_next[10] = P2_W'(r_reg[1]) * P2_W'(cfg.rot_y);
        n_next[11] = P2_W'(r_reg[2]) * P2_W'(cfg.rot_x);
    end

    // Stage 4: vector part of r * conj(q), rounded, plus translation
    always_comb
    begin
        s2[0] = -S2_W'(n_reg[0]) + S2_W'(n_reg[1]) - S2_W'(n_reg[2])  + S2_W'(n_reg[3]);
        s2[1] = -S2_W'(n_reg[4]) + S2_W'(n_reg[5]) + S2_W'(n_reg[6])  - S2_W'(n_reg[7]);
        s2[2] = -S2_W'(n_reg[8]) + S2_W'(n_reg[9]) - S2_W'(n_reg[10]) + S2_W'(n_reg[11]);
        o_next[0] = O_W'((s2[0] + HALF2) >>> QUAT_FRAC) + O_W'(cfg.shift_x);
        o_next[1] = O_W'((s2[1] + HALF2) >>> QUAT_FRAC) + O_W'(cfg.shift_y);
        o_next[2] = O_W'((s2[2] + HALF2) >>> QUAT_FRAC) + O_W'(cfg.shift_z);
    end

    // Stage 5: saturate to the coordinate range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // in range when all bits above the sign bit match it
            sat[i] = (o_reg[i][O_W-1:COORD_BITS-1] != {(O_W-COORD_BITS+1){1'b0}}) &&
                     (o_reg[i][O_W-1:COORD_BITS-1] != {(O_W-COORD_BITS+1){1'b1}});
            if (!sat[i])
            begin
                res_next[i] = o_reg[i][COORD_BITS-1:0];
            end
            else if (o_reg[i][O_W-1])
            begin
                res_next[i] = C_MIN;
            end
            else
            begin
                res_next[i] = C_MAX;
            end
        end
        ovf_next = |sat;
    end

    assign vld_next = {vld_reg[3:0], in_valid};

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        r_reg   <= r_next;
        n_reg   <= n_next;
        o_reg   <= o_next;
        res_reg <= res_next;
        ovf_reg <= ovf_next;
    end

    assign out_valid = vld_reg[4];
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_ovf   = ovf_reg;

endmodule

// File: hdl/quaternion_vertex_transform.sv
// A vertex accepted on start gives its result with done once it has passed the stage registers m, r, n, o and res.
// Throughput: one vertex per cycle; busy stays low since the five-stage pipeline never stalls.
// The two multiply stages each form twelve products in parallel.
// Reset loads w just under one with zero x, y, z and translation, and empties the pipeline.
// Results are strobed for one cycle on done; the receiver cannot hold them off.
// Top level: configuration registers and the rotate/translate pipeline.
module quaternion_vertex_transform (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_x,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_y,
    input  logic signed [qvt_pkg::COORD_BITS-1:0]  in_z,
    output logic                                   done,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_x,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_y,
    output logic signed [qvt_pkg::COORD_BITS-1:0]  out_z,
    output logic                                   overflow,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qvt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [qvt_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import qvt_pkg::*;

    qvt_cfg_t cfg_reg;
    qvt_cfg_t cfg_next;
    logic     accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROT_W:   cfg_next.rot_w   = cfg_data[QUAT_BITS-1:0];
                REG_ROT_X:   cfg_next.rot_x   = cfg_data[QUAT_BITS-1:0];
                REG_ROT_Y:   cfg_next.rot_y   = cfg_data[QUAT_BITS-1:0];
                REG_ROT_Z:   cfg_next.rot_z   = cfg_data[QUAT_BITS-1:0];
                REG_SHIFT_X: cfg_next.shift_x = cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Y: cfg_next.shift_y = cfg_data[COORD_BITS-1:0];
                REG_SHIFT_Z: cfg_next.shift_z = cfg_data[COORD_BITS-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_w   <= {1'b0, {(QUAT_BITS-1){1'b1}}};
            cfg_reg.rot_x   <= '0;
            cfg_reg.rot_y   <= '0;
            cfg_reg.rot_z   <= '0;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.shift_z <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Rotate, translate and saturate
    qvt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (accept),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .out_valid (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_ovf   (overflow)
    );

endmodule
